/* hdl/html_tag_stripper_core_macros.svh */
// ----------------------------------------------------------------------------
// HTML tag stripper assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef HTML_TAG_STRIPPER_CORE_MACROS_SVH
`define HTML_TAG_STRIPPER_CORE_MACROS_SVH

// Implication, checked only while out of reset
`define HTS_ASSERT_IMP(lbl, ck, rn, a, b, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
		else $error(msg);

// Next-cycle implication, checked only while out of reset
`define HTS_ASSERT_NXT(lbl, ck, rn, a, b, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
		else $error(msg);

// Implication checked at every edge, reset included
`define HTS_ASSERT_ALW(lbl, ck, a, b, msg) \
	lbl: assert property (@(posedge ck) (a) |-> (b)) \
		else $error(msg);

`endif

/* hdl/hts_pkg.sv */
// ----------------------------------------------------------------------------
// HTML tag stripper package
// Parser modes, character codes, result types and default sizes.
// ----------------------------------------------------------------------------
package hts_pkg;

	// result queue depth; must be 2 or more
	localparam int HTS_FIFO_DEPTH = 4;

	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	typedef enum logic [3:0] {
		MODE_TEXT      = 4'd0,
		MODE_LT        = 4'd1,
		MODE_TAG       = 4'd2,
		MODE_QUOTE     = 4'd3,
		MODE_BANG      = 4'd4,
		MODE_BANG_DASH = 4'd5,
		MODE_COMMENT   = 4'd6,
		MODE_CMT_DASH  = 4'd7,
		MODE_CMT_END   = 4'd8
	} mode_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       out_last;
	} res_t;

	// results produced by one input item
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

/* hdl/hts_in_if.sv */
// ----------------------------------------------------------------------------
// HTML tag stripper input channel
// Raw byte stream with a last-byte flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* hdl/hts_out_if.sv */
// ----------------------------------------------------------------------------
// HTML tag stripper output channel
// Stripped text bytes and end markers, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output has_byte, output out_last,
		input ready);
	modport sink (input valid, input out_byte, input has_byte, input out_last,
		output ready);
endinterface

/* hdl/hts_parser.sv */
// ----------------------------------------------------------------------------
// HTML tag stripper parser
// Mode register and next-mode decode; yields up to two results per byte.
// ----------------------------------------------------------------------------
module hts_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	output hts_pkg::push_t push
);

	hts_pkg::mode_t mode_q, mode_d;
	logic           quote_q, quote_d;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h41 && c <= 8'h5A);
	endfunction

	always_comb begin
		logic tag_q;
		logic [7:0] cq;
		push.cnt = 2'd0;
		push.r0  = '{out_byte: hts_pkg::CH_LT, has_byte: 1'b1, out_last: 1'b0};
		push.r1  = '{out_byte: in_byte, has_byte: 1'b1, out_last: 1'b0};
		mode_d   = mode_q;
		quote_d  = quote_q;
		tag_q    = (in_byte == hts_pkg::CH_DQUOTE) || (in_byte == hts_pkg::CH_SQUOTE);
		cq       = quote_q ? hts_pkg::CH_SQUOTE : hts_pkg::CH_DQUOTE;

		case (mode_q)
			hts_pkg::MODE_LT: begin
				if (in_byte == hts_pkg::CH_BANG) begin
					mode_d = hts_pkg::MODE_BANG;
				end else if (in_byte == hts_pkg::CH_SLASH || is_alnum(in_byte)) begin
					mode_d = hts_pkg::MODE_TAG;
				end else begin
					// not a tag: pass '<' and this byte
					push.cnt = 2'd2;
					mode_d   = hts_pkg::MODE_TEXT;
				end
			end
			hts_pkg::MODE_TAG, hts_pkg::MODE_BANG, hts_pkg::MODE_BANG_DASH: begin
				if (mode_q == hts_pkg::MODE_BANG && in_byte == hts_pkg::CH_DASH) begin
					mode_d = hts_pkg::MODE_BANG_DASH;
				end else if (mode_q == hts_pkg::MODE_BANG_DASH &&
					in_byte == hts_pkg::CH_DASH) begin
					mode_d = hts_pkg::MODE_COMMENT;
				end else if (tag_q) begin
					quote_d = (in_byte == hts_pkg::CH_SQUOTE);
					mode_d  = hts_pkg::MODE_QUOTE;
				end else if (in_byte == hts_pkg::CH_GT) begin
					mode_d = hts_pkg::MODE_TEXT;
				end else begin
					mode_d = hts_pkg::MODE_TAG;
				end
			end
			hts_pkg::MODE_QUOTE: begin
				if (in_byte == cq) begin
					mode_d = hts_pkg::MODE_TAG;
				end
			end
			hts_pkg::MODE_COMMENT: begin
				if (in_byte == hts_pkg::CH_DASH) begin
					mode_d = hts_pkg::MODE_CMT_DASH;
				end
			end
			hts_pkg::MODE_CMT_DASH: begin
				mode_d = (in_byte == hts_pkg::CH_DASH) ? hts_pkg::MODE_CMT_END :
					hts_pkg::MODE_COMMENT;
			end
			hts_pkg::MODE_CMT_END: begin
				if (in_byte == hts_pkg::CH_GT) begin
					mode_d = hts_pkg::MODE_TEXT;
				end else if (in_byte != hts_pkg::CH_DASH) begin
					mode_d = hts_pkg::MODE_COMMENT;
				end
			end
			default: begin
				if (in_byte == hts_pkg::CH_LT) begin
					mode_d = hts_pkg::MODE_LT;
				end else begin
					push.cnt = 2'd1;
					push.r0.out_byte = in_byte;
					mode_d = hts_pkg::MODE_TEXT;
				end
			end
		endcase

		if (in_last) begin
			case (push.cnt)
				2'd0: begin
					push.cnt = 2'd1;
					push.r0  = '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b1};
				end
				2'd1: begin
					push.r0.out_last = 1'b1;
				end
				default: begin
					push.r1.out_last = 1'b1;
				end
			endcase
			mode_d  = hts_pkg::MODE_TEXT;
			quote_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= hts_pkg::MODE_TEXT;
			quote_q <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_d;
			quote_q <= quote_d;
		end
	end

endmodule

/* hdl/hts_fifo.sv */
// ----------------------------------------------------------------------------
// HTML tag stripper result queue
// Small register queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module hts_fifo #(
	parameter int DEPTH = hts_pkg::HTS_FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_en,
	input  hts_pkg::push_t push,
	output logic           room2,
	output logic           valid,
	input  logic           ready,
	output hts_pkg::res_t  head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hts_pkg::res_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q, wr_p1, wr_p2;
	logic [CW-1:0] cnt_q;
	logic [1:0]    n_push;
	logic          pop;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign n_push = push_en ? push.cnt : 2'd0;
	assign pop    = valid && ready;
	assign valid  = (cnt_q != '0);
	assign room2  = (cnt_q <= CW'(DEPTH - 2));
	assign head   = mem_q[rd_q];
	assign wr_p1  = ptr_inc(wr_q);
	assign wr_p2  = ptr_inc(wr_p1);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (n_push)
				2'd1:    wr_q <= wr_p1;
				2'd2:    wr_q <= wr_p2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			cnt_q <= cnt_q + CW'(n_push) - CW'(pop);
		end
	end

endmodule

/* hdl/html_tag_stripper_core.sv */
// Input path: input register, parser, then the result queue that drives the output.
// Throughput: one input item per cycle while the output side keeps up; an item
//   yields 0, 1 or 2 results, drained at one per cycle through the result queue.
// The input register advances only when the queue has room for two results.
// Reset (arst_n low, asynchronous): parser back to text mode, quote flag and queue
//   cleared, input register empty.
// ----------------------------------------------------------------------------
// HTML tag stripper core
// Drops HTML tags and comments from a byte stream and passes the text.
// ----------------------------------------------------------------------------
module html_tag_stripper_core #(
	parameter int FIFO_DEPTH = hts_pkg::HTS_FIFO_DEPTH
) (
	input logic      clk,
	input logic      arst_n,
	hts_in_if.sink   rx,
	hts_out_if.source tx
);

	// input stage: one byte held for the parser
	logic          v_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	logic          room2;
	logic          adv;
	hts_pkg::push_t push;
	hts_pkg::res_t  head;

	// parser consumes the held item once the queue can take both possible results
	assign adv      = v_s1 && room2;
	assign rx.ready = !v_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.in_byte;
			last_s1 <= rx.in_last;
		end
	end

	// mode machine: tags, quoted values, comments and the '<' lookahead
	hts_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.push    (push)
	);

	// result queue doubles as the output register and skid for pair results
	hts_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_en (adv),
		.push    (push),
		.room2   (room2),
		.valid   (tx.valid),
		.ready   (tx.ready),
		.head    (head)
	);

	assign tx.out_byte = head.out_byte;
	assign tx.has_byte = head.has_byte;
	assign tx.out_last = head.out_last;

endmodule

/* hdl/hts_checker.sv */
// ----------------------------------------------------------------------------
// HTML tag stripper port checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "html_tag_stripper_core_macros.svh"

module hts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_ready,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] tx_out_byte,
	input logic       tx_has_byte,
	input logic       tx_out_last
);

	logic       tx_stall;
	logic [9:0] tx_res;
	logic       tx_bare;
	logic       end_mark;

	assign tx_stall = tx_valid && !tx_ready;
	assign tx_res   = {tx_out_byte, tx_has_byte, tx_out_last};
	assign tx_bare  = tx_valid && !tx_has_byte;
	assign end_mark = tx_out_last && (tx_out_byte == 8'h00);

	// a stalled result holds
	`HTS_ASSERT_NXT(a_tx_hold, clk, arst_n, tx_stall, tx_valid && $stable(tx_res), "item not held")

	// a result without a byte is only ever the end marker
	`HTS_ASSERT_IMP(a_bare_end, clk, arst_n, tx_bare, end_mark, "bare item is not an end marker")

	// input back-pressure only while results are waiting
	`HTS_ASSERT_ALW(a_stall_cause, clk, !rx_ready, tx_valid, "input stalled, no item waiting")

	// reset empties the result queue
	`HTS_ASSERT_ALW(a_reset_empty, clk, !arst_n, !tx_valid, "result shown during reset")

endmodule

bind html_tag_stripper_core hts_checker u_hts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_ready    (rx.ready),
	.tx_valid    (tx.valid),
	.tx_ready    (tx.ready),
	.tx_out_byte (tx.out_byte),
	.tx_has_byte (tx.has_byte),
	.tx_out_last (tx.out_last)
);

/* tb/sv/html_tag_stripper_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTML tag stripper core testbench
// Directed table of byte sequences (bounds, tags, quotes, comments, pass-through
// pairs, last-byte markers), then randomly built HTML fragments with noise.
// Results are checked in order against typed rows or a behavioural parser copy.
// ----------------------------------------------------------------------------
module html_tag_stripper_core_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int QUIET_FROM   = 850;	// no idling on either side after this many
	localparam int PAUSE_AT     = 500;	// sender drains the block once here
	localparam int END_CYCLES   = 20;

	// one row of the directed table; the expectation is only used when typed is set
	typedef struct {
		logic [7:0]    b;
		logic          last;
		bit            typed;
		int            n;
		hts_pkg::res_t e0;
		hts_pkg::res_t e1;
	} dir_row_t;

	logic clk;
	logic arst_n;

	hts_in_if  rx_ch ();
	hts_out_if tx_ch ();

	html_tag_stripper_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	// parser copy, advanced at every accepted input item
	hts_pkg::mode_t strip_mode   = hts_pkg::MODE_TEXT;
	bit             quote_single = 1'b0;

	hts_pkg::res_t stripped_q[$];	// text bytes and end markers still owed by the block
	dir_row_t      dir_rows[$];
	int            err_count  = 0;
	int            cycle_cnt  = 0;
	bit            quiet      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch: %s", msg);
		err_count++;
	endtask

	function automatic hts_pkg::res_t res(input logic [7:0] b, input logic h,
		input logic l);
		hts_pkg::res_t r;
		r.out_byte = b;
		r.has_byte = h;
		r.out_last = l;
		return r;
	endfunction

	// byte inside a tag body: quotes open a value, an unquoted '>' closes the tag
	function automatic void tag_body(input logic [7:0] c);
		if (c == hts_pkg::CH_DQUOTE || c == hts_pkg::CH_SQUOTE) begin
			quote_single = (c == hts_pkg::CH_SQUOTE);
			strip_mode   = hts_pkg::MODE_QUOTE;
		end else if (c == hts_pkg::CH_GT) begin
			strip_mode = hts_pkg::MODE_TEXT;
		end else begin
			strip_mode = hts_pkg::MODE_TAG;
		end
	endfunction

	// one input byte through the parser; returns how many results it gives
	function automatic int strip_byte(input logic [7:0] c, input logic last,
		output hts_pkg::res_t r0, output hts_pkg::res_t r1);
		int            n;
		bit            alnum;
		hts_pkg::res_t tmp[2];
		n     = 0;
		alnum = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		tmp[0] = '0;
		tmp[1] = '0;
		case (strip_mode)
			hts_pkg::MODE_LT: begin
				if (c == hts_pkg::CH_BANG) begin
					strip_mode = hts_pkg::MODE_BANG;
				end else if (c == hts_pkg::CH_SLASH || alnum) begin
					strip_mode = hts_pkg::MODE_TAG;
				end else begin
					// '<' that opens nothing: both bytes go through
					tmp[0] = res(hts_pkg::CH_LT, 1'b1, 1'b0);
					tmp[1] = res(c, 1'b1, 1'b0);
					n = 2;
					strip_mode = hts_pkg::MODE_TEXT;
				end
			end
			hts_pkg::MODE_TAG:       tag_body(c);
			hts_pkg::MODE_QUOTE: begin
				if (c == (quote_single ? hts_pkg::CH_SQUOTE : hts_pkg::CH_DQUOTE))
					strip_mode = hts_pkg::MODE_TAG;
			end
			hts_pkg::MODE_BANG: begin
				if (c == hts_pkg::CH_DASH) strip_mode = hts_pkg::MODE_BANG_DASH;
				else tag_body(c);
			end
			hts_pkg::MODE_BANG_DASH: begin
				if (c == hts_pkg::CH_DASH) strip_mode = hts_pkg::MODE_COMMENT;
				else tag_body(c);
			end
			hts_pkg::MODE_COMMENT: begin
				if (c == hts_pkg::CH_DASH) strip_mode = hts_pkg::MODE_CMT_DASH;
			end
			hts_pkg::MODE_CMT_DASH: begin
				strip_mode = (c == hts_pkg::CH_DASH) ? hts_pkg::MODE_CMT_END :
					hts_pkg::MODE_COMMENT;
			end
			hts_pkg::MODE_CMT_END: begin
				if (c == hts_pkg::CH_GT) strip_mode = hts_pkg::MODE_TEXT;
				else if (c != hts_pkg::CH_DASH) strip_mode = hts_pkg::MODE_COMMENT;
			end
			default: begin
				if (c == hts_pkg::CH_LT) begin
					strip_mode = hts_pkg::MODE_LT;
				end else begin
					tmp[0] = res(c, 1'b1, 1'b0);
					n = 1;
					strip_mode = hts_pkg::MODE_TEXT;
				end
			end
		endcase
		if (last) begin
			// nothing to carry the flag: bare end marker
			if (n == 0) begin
				tmp[0] = res(8'h00, 1'b0, 1'b0);
				n = 1;
			end
			tmp[n-1].out_last = 1'b1;
			strip_mode   = hts_pkg::MODE_TEXT;
			quote_single = 1'b0;
		end
		r0 = tmp[0];
		r1 = tmp[1];
		return n;
	endfunction

	// Present one item at the falling edge, hold it until accepted, then log what
	// the block owes for it. Entered and left just after a falling edge.
	task automatic send_item(input logic [7:0] b, input logic last, input bit typed,
		input int n_typed, input hts_pkg::res_t e0, input hts_pkg::res_t e1);
		hts_pkg::res_t p0;
		hts_pkg::res_t p1;
		int            n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			rx_ch.valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		rx_ch.valid   = 1'b1;
		rx_ch.in_byte = b;
		rx_ch.in_last = last;
		do @(posedge clk); while (!rx_ch.ready);
		n = strip_byte(b, last, p0, p1);
		// typed rows overrule the parser copy's output, not its state
		if (typed) begin
			n  = n_typed;
			p0 = e0;
			p1 = e1;
		end
		if (n > 0) stripped_q.insert(stripped_q.size(), p0);
		if (n > 1) stripped_q.insert(stripped_q.size(), p1);
		@(negedge clk);
	endtask

	function automatic logic [7:0] rand_alnum();
		case ($urandom_range(0, 2))
			0:       return 8'($urandom_range("0", "9"));
			1:       return 8'($urandom_range("a", "z"));
			default: return 8'($urandom_range("A", "Z"));
		endcase
	endfunction

	// plain text byte, mostly printable and never '<' in the printable case
	function automatic logic [7:0] rand_text();
		logic [7:0] c;
		if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
		do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == hts_pkg::CH_LT);
		return c;
	endfunction

	// append one randomly shaped HTML fragment to q
	task automatic build_fragment(ref logic [7:0] q[$]);
		logic [7:0] c;
		logic [7:0] qt;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				repeat ($urandom_range(1, 6)) q.insert(q.size(), rand_text());
			end
			3, 4: begin
				// element tag, opening or closing, with quoted attributes
				q.insert(q.size(), hts_pkg::CH_LT);
				q.insert(q.size(),
					$urandom_range(0, 3) == 0 ? hts_pkg::CH_SLASH : rand_alnum());
				repeat ($urandom_range(0, 4)) q.insert(q.size(), rand_alnum());
				repeat ($urandom_range(0, 2)) begin
					q.insert(q.size(), " ");
					repeat ($urandom_range(1, 3)) q.insert(q.size(), rand_alnum());
					q.insert(q.size(), "=");
					qt = $urandom_range(0, 1) ? hts_pkg::CH_SQUOTE : hts_pkg::CH_DQUOTE;
					q.insert(q.size(), qt);
					repeat ($urandom_range(0, 4)) begin
						case ($urandom_range(0, 3))
							0:       q.insert(q.size(), hts_pkg::CH_GT);
							1:       q.insert(q.size(), qt == hts_pkg::CH_SQUOTE ?
								hts_pkg::CH_DQUOTE : hts_pkg::CH_SQUOTE);
							default: q.insert(q.size(), rand_text());
						endcase
					end
					if ($urandom_range(0, 7) != 0) q.insert(q.size(), qt);
				end
				q.insert(q.size(), hts_pkg::CH_GT);
			end
			5: begin
				q.insert(q.size(), hts_pkg::CH_LT);
				q.insert(q.size(), hts_pkg::CH_BANG);
				q.insert(q.size(), hts_pkg::CH_DASH);
				q.insert(q.size(), hts_pkg::CH_DASH);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 3))
						0:       q.insert(q.size(), hts_pkg::CH_DASH);
						1:       q.insert(q.size(), hts_pkg::CH_GT);
						default: q.insert(q.size(), rand_text());
					endcase
				end
				repeat ($urandom_range(2, 4)) q.insert(q.size(), hts_pkg::CH_DASH);
				q.insert(q.size(), hts_pkg::CH_GT);
			end
			6: begin
				// declaration, sometimes with a lone dash after the bang
				q.insert(q.size(), hts_pkg::CH_LT);
				q.insert(q.size(), hts_pkg::CH_BANG);
				if ($urandom_range(0, 2) == 0) q.insert(q.size(), hts_pkg::CH_DASH);
				repeat ($urandom_range(0, 5)) q.insert(q.size(), rand_alnum());
				if ($urandom_range(0, 2) == 0) q.insert(q.size(), hts_pkg::CH_DQUOTE);
				if ($urandom_range(0, 2) == 0) q.insert(q.size(), hts_pkg::CH_DQUOTE);
				q.insert(q.size(), hts_pkg::CH_GT);
			end
			7: begin
				// pass-through pair
				q.insert(q.size(), hts_pkg::CH_LT);
				if ($urandom_range(0, 3) == 0) begin
					q.insert(q.size(), hts_pkg::CH_LT);
				end else begin
					do c = 8'($urandom_range(0, 255));
					while ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
						(c >= "A" && c <= "Z") || c == hts_pkg::CH_SLASH ||
						c == hts_pkg::CH_BANG);
					q.insert(q.size(), c);
				end
			end
			default: begin
				repeat ($urandom_range(1, 4)) q.insert(q.size(), 8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// receiver: random runs of ready and stalls, always ready once quiet
	initial begin
		int run;
		run = 0;
		tx_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				tx_ch.ready = 1'b1;
			end else begin
				if (run == 0) begin
					if ($urandom_range(0, 3) == 0) begin
						tx_ch.ready = 1'b0;
						run = $urandom_range(1, 11);
					end else begin
						tx_ch.ready = 1'b1;
						run = $urandom_range(1, 20);
					end
				end
				run--;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		hts_pkg::res_t got;
		hts_pkg::res_t want;
		if (arst_n && tx_ch.valid && tx_ch.ready) begin
			got = res(tx_ch.out_byte, tx_ch.has_byte, tx_ch.out_last);
			if (stripped_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte=%02h has=%b last=%b",
					got.out_byte, got.has_byte, got.out_last));
			end else begin
				want = stripped_q.pop_front();
				if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
					got.out_last !== want.out_last)
					report_mismatch($sformatf("byte=%02h/%02h has=%b/%b last=%b/%b (got/exp)",
						got.out_byte, want.out_byte, got.has_byte, want.has_byte,
						got.out_last, want.out_last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
		input int n, input hts_pkg::res_t e0, input hts_pkg::res_t e1);
		dir_row_t r;
		r.b     = b;
		r.last  = last;
		r.typed = typed;
		r.n     = n;
		r.e0    = e0;
		r.e1    = e1;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	initial begin
		logic [7:0]    frag[$];
		hts_pkg::res_t none;
		int            sent;
		bit            paused;
		logic          lst;
		none   = '0;
		sent   = 0;
		paused = 1'b0;

		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.in_byte = 8'h00;
		rx_ch.in_last = 1'b0;

		// bounds of the byte straight after reset
		add_row(8'h00, 1'b0, 1'b1, 1, res(8'h00, 1'b1, 1'b0), none);
		add_row(8'hFF, 1'b0, 1'b1, 1, res(8'hFF, 1'b1, 1'b0), none);
		// '<' '<' is a pass-through pair
		add_row(hts_pkg::CH_LT, 1'b0, 1'b1, 0, none, none);
		add_row(hts_pkg::CH_LT, 1'b0, 1'b1, 2, res(hts_pkg::CH_LT, 1'b1, 1'b0),
			res(hts_pkg::CH_LT, 1'b1, 1'b0));
		// tag opened by a digit, quoted '>' kept inside the value
		add_row(hts_pkg::CH_LT,     1'b0, 1'b0, 0, none, none);
		add_row("7",                1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_DQUOTE, 1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_GT,     1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_DQUOTE, 1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_GT,     1'b0, 1'b0, 0, none, none);
		// comment with a single dash inside and extra dashes before the close
		add_row(hts_pkg::CH_LT,   1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_BANG, 1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_DASH, 1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_DASH, 1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_DASH, 1'b0, 1'b0, 0, none, none);
		add_row("x",              1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_DASH, 1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_DASH, 1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_DASH, 1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_GT,   1'b0, 1'b0, 0, none, none);
		// short bang with a lone dash, then a single-quoted value
		add_row(hts_pkg::CH_LT,     1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_BANG,   1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_DASH,   1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_SQUOTE, 1'b0, 1'b0, 0, none, none);
		add_row(hts_pkg::CH_GT,     1'b0, 1'b0, 0, none, none);
		// last byte swallowed in the quote gives a bare end marker
		add_row(8'hFF, 1'b1, 1'b1, 1, res(8'h00, 1'b0, 1'b1), none);
		// state back in text after the last byte
		add_row("Z",   1'b1, 1'b1, 1, res("Z", 1'b1, 1'b1), none);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].n,
				dir_rows[i].e0, dir_rows[i].e1);

		// random fragments, mostly well-formed HTML with noise mixed in
		while (sent < RANDOM_ITEMS) begin
			frag.delete();
			build_fragment(frag);
			foreach (frag[i]) begin
				lst = ($urandom_range(0, 39) == 0) ||
					(i == frag.size() - 1 && $urandom_range(0, 5) == 0);
				send_item(frag[i], lst, 1'b0, 0, none, none);
				sent++;
				if (sent >= QUIET_FROM) quiet = 1'b1;
			end
			// one drain in the middle: hold the sender until nothing is owed
			if (!paused && sent >= PAUSE_AT) begin
				paused = 1'b1;
				rx_ch.valid = 1'b0;
				while (stripped_q.size() != 0) @(negedge clk);
			end
		end
		rx_ch.valid = 1'b0;

		while (stripped_q.size() != 0) @(negedge clk);
		repeat (END_CYCLES) @(negedge clk);

		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
